FILE: rtl/rcpfa_pkg.sv
// ----------------------------------------------------------------------------
// rcpfa_pkg: shared types and constants of the page-frame allocator
// Operation, status and register index codes, field widths and fixed limits.
// ----------------------------------------------------------------------------
package rcpfa_pkg;

  // Field widths of the request, the result and the registers.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned PGNUM_W  = 20;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned GRANT_W  = 12;
  localparam int unsigned REFCNT_W = 8;
  localparam int unsigned FREE_W   = 13;
  localparam int unsigned CFG_W    = 13;

  // A share may not bring a count up to this value.
  localparam logic [REFCNT_W-1:0] COUNT_CEILING = 8'd255;

  // The free count saturates at this value.
  localparam logic [FREE_W-1:0] FREE_SAT = 13'd8191;

  // Register reset values.
  localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 13'd256;
  localparam logic [CFG_W-1:0] PAGE_LIMIT_RST = 13'd4096;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SHARE   = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OOM      = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOT_HELD = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/rcpfa_ram.sv
// ----------------------------------------------------------------------------
// rcpfa_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rcpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/refcount_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// refcount_page_frame_allocator_top: reference-counted page-frame allocator
// Keeps an 8-bit reference count per page plus an occupancy bitmap, and
// serves allocate, release and share requests with a free-page count.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake         | Payload
//  ----------+-------------------+-----------------------------------------
//  request   | start, busy       | operation_i, page_number_i
//  result    | done_o            | status_o, granted_page_o,
//            |                   | reference_count_o, free_count_o
//  config    | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
//  Every item sweeps the occupancy bitmap one word per cycle through a single
//  mask, popcount and find-first unit (64 pages per word at 4096 pages);
//  release and share add a step that reads the addressed page's bitmap word.
//  After reset a clearing pass zeroes both memories, and busy stays high
//  meanwhile. The result strobe lasts one cycle and cannot be held.
//
module refcount_page_frame_allocator_top #(
  parameter int unsigned PAGES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [rcpfa_pkg::OP_W-1:0]         operation_i,
  input  logic [rcpfa_pkg::PGNUM_W-1:0]      page_number_i,
  output logic                               done_o,
  output logic [rcpfa_pkg::STATUS_W-1:0]     status_o,
  output logic [rcpfa_pkg::GRANT_W-1:0]      granted_page_o,
  output logic [rcpfa_pkg::REFCNT_W-1:0]     reference_count_o,
  output logic [rcpfa_pkg::FREE_W-1:0]       free_count_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [rcpfa_pkg::CFG_W-1:0]        cfg_wdata_i
);

  // Geometry of the bitmap and the counters.
  localparam int unsigned PW     = $clog2(PAGES);
  localparam int unsigned WORD_W = (PAGES >= 64) ? 64 : 16;
  localparam int unsigned BW     = $clog2(WORD_W);
  localparam int unsigned WORDS  = (PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned WIW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PGW    = WIW + BW;
  localparam int unsigned CW     = ((PGW > 20) ? PGW : 20) + 2;
  localparam int unsigned CNTW   = $clog2(PAGES + 1);
  localparam int unsigned FCW    = ((CNTW > 13) ? CNTW : 13) + 1;
  localparam int unsigned PCW    = BW + 1;
  localparam int unsigned RW     = rcpfa_pkg::REFCNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_READ,
    S_WRITE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [rcpfa_pkg::CFG_W-1:0] first_q, limit_q;

  // Request registers.
  rcpfa_pkg::op_e               op_q;
  logic [rcpfa_pkg::PGNUM_W-1:0] pg_q;

  // Clearing pass and sweep counters.
  logic [PW-1:0]  clr_q;
  logic [WIW-1:0] rd_q;

  // Sweep pipeline: read data stage and masked stage.
  logic           vld1_q, vld2_q;
  logic [WIW-1:0] tag1_q, tag2_q;
  logic [WORD_W-1:0] free_q, raw2_q;

  // Sweep results.
  logic [CNTW-1:0]   acc_q;
  logic              found_q;
  logic [WIW-1:0]    fword_q;
  logic [BW-1:0]     fbit_q;
  logic [WORD_W-1:0] fraw_q;

  // Result registers.
  logic                            done_q;
  logic [rcpfa_pkg::STATUS_W-1:0]  status_q;
  logic [rcpfa_pkg::GRANT_W-1:0]   grant_q;
  logic [RW-1:0]                   refc_q;
  logic [rcpfa_pkg::FREE_W-1:0]    free_cnt_q;

  // Memory ports.
  logic              bmp_we;
  logic [WIW-1:0]    bmp_waddr, bmp_raddr;
  logic [WORD_W-1:0] bmp_wdata, bmp_rdata;
  logic              ref_we;
  logic [PW-1:0]     ref_waddr;
  logic [RW-1:0]     ref_wdata, ref_rdata;

  // Window bounds, shared by the mask unit and the range check.
  logic [CW-1:0] first_e, end_e, pg_e;

  assign first_e = CW'(first_q);
  assign end_e   = (CW'(limit_q) < CW'(PAGES)) ? CW'(limit_q) : CW'(PAGES);
  assign pg_e    = CW'(pg_q);

  // Occupancy bitmap: one bit per page, set while the count is non-zero.
  rcpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_we),
    .waddr_i (bmp_waddr),
    .wdata_i (bmp_wdata),
    .raddr_i (bmp_raddr),
    .rdata_o (bmp_rdata)
  );

  // Reference count store.
  rcpfa_ram #(
    .WIDTH (RW),
    .DEPTH (PAGES)
  ) u_refcnt_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (pg_q[PW-1:0]),
    .rdata_o (ref_rdata)
  );

  // Window mask of the word coming out of the bitmap.
  logic [CW-1:0]     lo_e, d_lo, d_hi;
  logic [WORD_W-1:0] m_lo, m_hi, free_bits;

  always_comb begin
    lo_e = CW'({tag1_q, BW'(0)});
    d_lo = first_e - lo_e;
    d_hi = end_e - lo_e;
    if (first_e <= lo_e) begin
      m_lo = '1;
    end else if (d_lo >= CW'(WORD_W)) begin
      m_lo = '0;
    end else begin
      m_lo = {WORD_W{1'b1}} << d_lo[BW-1:0];
    end
    if (end_e <= lo_e) begin
      m_hi = '0;
    end else if (d_hi >= CW'(WORD_W)) begin
      m_hi = '1;
    end else begin
      m_hi = ~({WORD_W{1'b1}} << d_hi[BW-1:0]);
    end
    free_bits = ~bmp_rdata & m_lo & m_hi;
  end

  // Popcount and lowest free bit of the masked word.
  logic [PCW-1:0] pop;
  logic [BW-1:0]  low_bit;

  always_comb begin
    pop     = '0;
    low_bit = '0;
    for (int i = 0; i < WORD_W; i++) begin
      pop = pop + PCW'(free_q[i]);
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        low_bit = BW'(i);
      end
    end
  end

  // Request outcome, evaluated in the write step, and the clearing pass writes.
  logic                            in_win;
  logic [rcpfa_pkg::STATUS_W-1:0]  res_status;
  logic [rcpfa_pkg::GRANT_W-1:0]   res_grant;
  logic [RW-1:0]                   res_refc, cnt_dec;
  logic                            res_inc, res_dec;
  logic [WIW-1:0]                  pg_word;
  logic [BW-1:0]                   pg_bit;
  logic [PGW-1:0]                  fpage;
  logic [FCW-1:0]                  free_sum;
  logic [rcpfa_pkg::FREE_W-1:0]    free_sat;

  assign pg_word = pg_q[PGW-1:BW];
  assign pg_bit  = pg_q[BW-1:0];
  assign fpage   = {fword_q, fbit_q};
  assign in_win  = (pg_e >= first_e) && (pg_e < end_e);
  assign cnt_dec = ref_rdata - RW'(1);

  always_comb begin
    res_status = rcpfa_pkg::ST_OK;
    res_grant  = '0;
    res_refc   = '0;
    res_inc    = 1'b0;
    res_dec    = 1'b0;
    ref_we     = 1'b0;
    ref_waddr  = pg_q[PW-1:0];
    ref_wdata  = '0;
    bmp_we     = 1'b0;
    bmp_waddr  = pg_word;
    bmp_wdata  = '0;
    if (state_q == S_CLEAR) begin
      ref_we    = 1'b1;
      ref_waddr = clr_q;
      bmp_we    = (clr_q < PW'(WORDS - 1)) || (clr_q == PW'(WORDS - 1));
      bmp_waddr = WIW'(clr_q);
    end else if (state_q == S_WRITE) begin
      unique case (op_q)
        rcpfa_pkg::OP_ALLOC: begin
          if (found_q) begin
            ref_we     = 1'b1;
            ref_waddr  = PW'(fpage);
            ref_wdata  = RW'(1);
            bmp_we     = 1'b1;
            bmp_waddr  = fword_q;
            bmp_wdata  = fraw_q | (WORD_W'(1) << fbit_q);
            res_grant  = rcpfa_pkg::GRANT_W'(fpage);
            res_refc   = RW'(1);
            res_dec    = 1'b1;
          end else begin
            res_status = rcpfa_pkg::ST_OOM;
          end
        end
        rcpfa_pkg::OP_RELEASE, rcpfa_pkg::OP_SHARE: begin
          if (!in_win) begin
            res_status = rcpfa_pkg::ST_RANGE;
          end else if (ref_rdata == '0) begin
            res_status = rcpfa_pkg::ST_NOT_HELD;
          end else if (op_q == rcpfa_pkg::OP_RELEASE) begin
            ref_we    = 1'b1;
            ref_wdata = cnt_dec;
            res_refc  = cnt_dec;
            // The last reference frees the page in the bitmap.
            if (cnt_dec == '0) begin
              bmp_we    = 1'b1;
              bmp_wdata = bmp_rdata & ~(WORD_W'(1) << pg_bit);
              res_inc   = 1'b1;
            end
          end else if (ref_rdata >= rcpfa_pkg::COUNT_CEILING - RW'(1)) begin
            res_status = rcpfa_pkg::ST_OVERFLOW;
            res_refc   = ref_rdata;
          end else begin
            ref_we    = 1'b1;
            ref_wdata = ref_rdata + RW'(1);
            res_refc  = ref_rdata + RW'(1);
          end
        end
        default: begin
          res_status = rcpfa_pkg::ST_OK;
        end
      endcase
    end
    free_sum = FCW'(acc_q) + FCW'(res_inc) - FCW'(res_dec);
    free_sat = (free_sum > FCW'(rcpfa_pkg::FREE_SAT)) ? rcpfa_pkg::FREE_SAT
                                                       : free_sum[12:0];
  end

  // Bitmap read address: sweep counter, or the addressed page's word.
  assign bmp_raddr = (state_q == S_READ) ? pg_word : rd_q;

  // Sequencer, sweep pipeline, configuration and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      first_q    <= rcpfa_pkg::FIRST_PAGE_RST;
      limit_q    <= rcpfa_pkg::PAGE_LIMIT_RST;
      op_q       <= rcpfa_pkg::OP_ALLOC;
      pg_q       <= '0;
      clr_q      <= '0;
      rd_q       <= '0;
      vld1_q     <= 1'b0;
      vld2_q     <= 1'b0;
      tag1_q     <= '0;
      tag2_q     <= '0;
      free_q     <= '0;
      raw2_q     <= '0;
      acc_q      <= '0;
      found_q    <= 1'b0;
      fword_q    <= '0;
      fbit_q     <= '0;
      fraw_q     <= '0;
      done_q     <= 1'b0;
      status_q   <= '0;
      grant_q    <= '0;
      refc_q     <= '0;
      free_cnt_q <= '0;
    end else begin
      // Configuration writes are taken in any state.
      if (cfg_we_i) begin
        if (cfg_idx_i == rcpfa_pkg::CFG_FIRST_PAGE) begin
          first_q <= cfg_wdata_i;
        end else begin
          limit_q <= cfg_wdata_i;
        end
      end

      // Sweep pipeline runs freely behind the read counter.
      vld1_q <= (state_q == S_SWEEP);
      tag1_q <= rd_q;
      vld2_q <= vld1_q;
      tag2_q <= tag1_q;
      free_q <= free_bits;
      raw2_q <= bmp_rdata;
      if (vld2_q) begin
        acc_q <= acc_q + CNTW'(pop);
        if (!found_q && (free_q != '0)) begin
          found_q <= 1'b1;
          fword_q <= tag2_q;
          fbit_q  <= low_bit;
          fraw_q  <= raw2_q;
        end
      end

      // The result strobe follows the write step for one cycle.
      done_q <= (state_q == S_WRITE);

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == PW'(PAGES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= rcpfa_pkg::op_e'(operation_i);
            pg_q    <= page_number_i;
            rd_q    <= '0;
            acc_q   <= '0;
            found_q <= 1'b0;
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          rd_q <= rd_q + WIW'(1);
          if (rd_q == WIW'(WORDS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!vld1_q && !vld2_q) begin
            state_q <= (op_q == rcpfa_pkg::OP_ALLOC) ? S_WRITE : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          status_q   <= res_status;
          grant_q    <= res_grant;
          refc_q     <= res_refc;
          free_cnt_q <= free_sat;
          state_q    <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_page_o    = grant_q;
  assign reference_count_o = refc_q;
  assign free_count_o      = free_cnt_q;

endmodule

FILE: sim/rcpfa_checker.sv
// ----------------------------------------------------------------------------
// rcpfa_checker: result checker for the page-frame allocator
// Watches the request, result and register channels. Keeps its own copy of
// the page counts and the window, works out each result when a request is
// taken, and compares every result with the oldest one still owed.
// ----------------------------------------------------------------------------
module rcpfa_checker #(
  parameter int unsigned PAGES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [rcpfa_pkg::OP_W-1:0]     operation_i,
  input  logic [rcpfa_pkg::PGNUM_W-1:0]  page_number_i,
  input  logic                           done_i,
  input  logic [rcpfa_pkg::STATUS_W-1:0] status_i,
  input  logic [rcpfa_pkg::GRANT_W-1:0]  granted_page_i,
  input  logic [rcpfa_pkg::REFCNT_W-1:0] reference_count_i,
  input  logic [rcpfa_pkg::FREE_W-1:0]   free_count_i,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [rcpfa_pkg::CFG_W-1:0]    cfg_wdata_i,
  output int unsigned                    failures_o,
  output int unsigned                    outstanding_o
);

  typedef struct packed {
    logic [rcpfa_pkg::STATUS_W-1:0] status;
    logic [rcpfa_pkg::GRANT_W-1:0]  granted;
    logic [rcpfa_pkg::REFCNT_W-1:0] refcnt;
    logic [rcpfa_pkg::FREE_W-1:0]   free;
  } frame_result_t;

  logic [rcpfa_pkg::REFCNT_W-1:0] page_refs [PAGES];
  int unsigned         first_page;
  int unsigned         page_limit;
  frame_result_t       owed_results [$];
  int unsigned         fail_total = 0;
  int unsigned         owed_count = 0;

  assign failures_o    = fail_total;
  assign outstanding_o = owed_count;

  // The window ends at the page limit or at the store size, whichever is lower.
  function automatic int unsigned window_top();
    return (page_limit < PAGES) ? page_limit : PAGES;
  endfunction

  // Free pages are counted over the present window and saturate.
  function automatic logic [rcpfa_pkg::FREE_W-1:0] window_free_count();
    int unsigned n;
    n = 0;
    for (int unsigned p = first_page; p < window_top(); p++) begin
      if (page_refs[p] == '0) n++;
    end
    return (n > rcpfa_pkg::FREE_SAT) ? rcpfa_pkg::FREE_SAT : rcpfa_pkg::FREE_W'(n);
  endfunction

  // Applies one request to the page counts and returns the result it owes.
  function automatic frame_result_t serve_request(logic [rcpfa_pkg::OP_W-1:0] op,
                                                  logic [rcpfa_pkg::PGNUM_W-1:0] pg);
    frame_result_t r;
    int unsigned   top;
    r        = '0;
    r.status = rcpfa_pkg::ST_OK;
    top      = window_top();
    case (op)
      rcpfa_pkg::OP_ALLOC: begin
        r.status = rcpfa_pkg::ST_OOM;
        for (int unsigned p = first_page; p < top; p++) begin
          if (page_refs[p] == '0) begin
            page_refs[p] = rcpfa_pkg::REFCNT_W'(1);
            r.status     = rcpfa_pkg::ST_OK;
            r.granted    = rcpfa_pkg::GRANT_W'(p);
            r.refcnt     = rcpfa_pkg::REFCNT_W'(1);
            break;
          end
        end
      end
      rcpfa_pkg::OP_RELEASE, rcpfa_pkg::OP_SHARE: begin
        if (pg < first_page || pg >= top) begin
          r.status = rcpfa_pkg::ST_RANGE;
        end else if (page_refs[pg] == '0) begin
          r.status = rcpfa_pkg::ST_NOT_HELD;
        end else if (op == rcpfa_pkg::OP_RELEASE) begin
          page_refs[pg] = page_refs[pg] - 1'b1;
          r.refcnt      = page_refs[pg];
        end else begin
          // A share may never bring the count up to the ceiling.
          if (page_refs[pg] + 1 >= rcpfa_pkg::COUNT_CEILING) begin
            r.status = rcpfa_pkg::ST_OVERFLOW;
          end else begin
            page_refs[pg] = page_refs[pg] + 1'b1;
          end
          r.refcnt = page_refs[pg];
        end
      end
      default: ;  // The unused code changes nothing.
    endcase
    r.free = window_free_count();
    return r;
  endfunction

  function automatic void check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_total++;
    end
  endfunction

  // Results are checked before a request taken at the same edge is applied.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      foreach (page_refs[i]) page_refs[i] = '0;
      first_page = rcpfa_pkg::FIRST_PAGE_RST;
      page_limit = rcpfa_pkg::PAGE_LIMIT_RST;
      owed_results.delete();
      owed_count <= 0;
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none owed, expected none, actual status %0d page %0d",
                   $time, status_i, granted_page_i);
          fail_total++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("granted_page", want.granted, granted_page_i);
          check_field("reference_count", want.refcnt, reference_count_i);
          check_field("free_count", want.free, free_count_i);
        end
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(serve_request(operation_i, page_number_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rcpfa_pkg::CFG_FIRST_PAGE: first_page = cfg_wdata_i;
          rcpfa_pkg::CFG_PAGE_LIMIT: page_limit = cfg_wdata_i;
          default: ;
        endcase
      end
      owed_count <= owed_results.size();
    end
  end

endmodule

FILE: sim/tb_refcount_page_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_refcount_page_frame_allocator_top: testbench of the page-frame allocator
// Sends a directed set of requests and then phases of random requests, each
// phase under its own page window, with share and release runs that drive a
// count to its ceiling. Results are checked by rcpfa_checker.
// ----------------------------------------------------------------------------
module tb_refcount_page_frame_allocator_top;

  localparam int unsigned PAGES          = 4096;
  localparam int unsigned ITEMS          = 1900;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 80;
  localparam int unsigned GRANT_KEEP     = 16;
  localparam int unsigned NPHASES        = 9;
  localparam logic [rcpfa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            start         = 1'b0;
  logic                            busy;
  logic [rcpfa_pkg::OP_W-1:0]      operation_i   = '0;
  logic [rcpfa_pkg::PGNUM_W-1:0]   page_number_i = '0;
  logic                            done_o;
  logic [rcpfa_pkg::STATUS_W-1:0]  status_o;
  logic [rcpfa_pkg::GRANT_W-1:0]   granted_page_o;
  logic [rcpfa_pkg::REFCNT_W-1:0]  reference_count_o;
  logic [rcpfa_pkg::FREE_W-1:0]    free_count_o;
  logic                            cfg_we_i      = 1'b0;
  logic                            cfg_idx_i     = 1'b0;
  logic [rcpfa_pkg::CFG_W-1:0]     cfg_wdata_i   = '0;

  int unsigned                     failures;
  int unsigned                     outstanding;
  int unsigned                     quiet_cycles  = 0;
  int unsigned                     sent          = 0;
  int unsigned                     win_lo        = rcpfa_pkg::FIRST_PAGE_RST;
  int unsigned                     win_hi        = rcpfa_pkg::PAGE_LIMIT_RST;
  logic [rcpfa_pkg::OP_W-1:0]      inflight_op   = '0;
  logic [rcpfa_pkg::GRANT_W-1:0]   grants [$];

  // Window of each random phase; the extremes and an empty window included.
  int unsigned ph_first [NPHASES] = '{256, 4088, 0, 100, 4096, 0, 8191, 10, 4000};
  int unsigned ph_limit [NPHASES] = '{4096, 4096, 16, 8191, 4096, 0, 5, 40, 4096};
  int unsigned ph_items [NPHASES] = '{150, 150, 200, 150, 40, 30, 30, 150, 200};
  bit          ph_burst [NPHASES] = '{0, 1, 0, 0, 0, 0, 0, 1, 0};

  always #2 clk_i = ~clk_i;

  refcount_page_frame_allocator_top #(
    .PAGES(PAGES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .page_number_i    (page_number_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_page_o   (granted_page_o),
    .reference_count_o(reference_count_o),
    .free_count_o     (free_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  rcpfa_checker #(
    .PAGES(PAGES)
  ) frame_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .operation_i      (operation_i),
    .page_number_i    (page_number_i),
    .done_i           (done_o),
    .status_i         (status_o),
    .granted_page_i   (granted_page_o),
    .reference_count_i(reference_count_o),
    .free_count_i     (free_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .failures_o       (failures),
    .outstanding_o    (outstanding)
  );

  // Remember the operation in flight so that granted pages can be reused.
  always @(posedge clk_i) begin
    if (start && !busy) inflight_op <= operation_i;
  end

  // Granted pages are picked up mid-cycle, clear of the driving edge.
  always @(negedge clk_i) begin
    if (rst_ni && done_o && status_o == rcpfa_pkg::ST_OK &&
        inflight_op == rcpfa_pkg::OP_ALLOC) begin
      grants.push_back(granted_page_o);
      if (grants.size() > GRANT_KEEP) void'(grants.pop_front());
    end
  end

  // Ends the run when neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The sender idles in 30 of a hundred items, then in 63, then never.
  function automatic int unsigned idle_percent();
    if (sent < ITEMS / 3) return 30;
    if (sent < 2 * ITEMS / 3) return 63;
    return 0;
  endfunction

  function automatic logic [rcpfa_pkg::OP_W-1:0] pick_op();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return rcpfa_pkg::OP_ALLOC;
    if (sel < 65) return rcpfa_pkg::OP_RELEASE;
    if (sel < 95) return rcpfa_pkg::OP_SHARE;
    return OP_UNUSED;
  endfunction

  // Mostly pages that were granted or lie in the window, some far outside.
  function automatic logic [rcpfa_pkg::PGNUM_W-1:0] pick_page();
    int unsigned top;
    int unsigned sel;
    top = (win_hi < PAGES) ? win_hi : PAGES;
    sel = $urandom_range(0, 99);
    if (sel < 45 && grants.size() != 0) begin
      return rcpfa_pkg::PGNUM_W'(grants[$urandom_range(0, grants.size() - 1)]);
    end
    if (sel < 70 && win_lo < top) begin
      return rcpfa_pkg::PGNUM_W'($urandom_range(win_lo, top - 1));
    end
    if (sel < 80) begin
      case ($urandom_range(0, 3))
        0:       return rcpfa_pkg::PGNUM_W'(win_lo - 1);
        1:       return rcpfa_pkg::PGNUM_W'(win_lo);
        2:       return rcpfa_pkg::PGNUM_W'(top - 1);
        default: return rcpfa_pkg::PGNUM_W'(top);
      endcase
    end
    if (sel < 90) return rcpfa_pkg::PGNUM_W'($urandom_range(0, 8191));
    return rcpfa_pkg::PGNUM_W'($urandom());
  endfunction

  // Holds the item until it is taken, then maybe leaves a gap.
  task automatic send_item(input logic [rcpfa_pkg::OP_W-1:0] op,
                           input logic [rcpfa_pkg::PGNUM_W-1:0] pg);
    start         <= 1'b1;
    operation_i   <= op;
    page_number_i <= pg;
    do @(posedge clk_i); while (busy);
    sent++;
    if ($urandom_range(0, 99) < idle_percent()) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
  endtask

  // Waits until every owed result has come back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
  endtask

  // Writes both window registers on back-to-back cycles.
  task automatic set_window(input int unsigned lo, input int unsigned hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rcpfa_pkg::CFG_FIRST_PAGE;
    cfg_wdata_i <= rcpfa_pkg::CFG_W'(lo);
    @(posedge clk_i);
    cfg_idx_i   <= rcpfa_pkg::CFG_PAGE_LIMIT;
    cfg_wdata_i <= rcpfa_pkg::CFG_W'(hi);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  // Takes a fresh page up to the count ceiling and partly back down.
  task automatic share_burst();
    logic [rcpfa_pkg::PGNUM_W-1:0] pg;
    send_item(rcpfa_pkg::OP_ALLOC, rcpfa_pkg::PGNUM_W'($urandom()));
    drain();
    pg = (grants.size() != 0) ? rcpfa_pkg::PGNUM_W'(grants[$])
                              : rcpfa_pkg::PGNUM_W'(win_lo);
    repeat ($urandom_range(252, 258)) send_item(rcpfa_pkg::OP_SHARE, pg);
    repeat ($urandom_range(1, 258)) send_item(rcpfa_pkg::OP_RELEASE, pg);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset window: grant, misses on every side, one share and two releases.
    send_item(rcpfa_pkg::OP_ALLOC, '0);
    send_item(OP_UNUSED, '1);
    send_item(rcpfa_pkg::OP_RELEASE, rcpfa_pkg::PGNUM_W'(255));
    send_item(rcpfa_pkg::OP_SHARE, rcpfa_pkg::PGNUM_W'(4096));
    send_item(rcpfa_pkg::OP_SHARE, '1);
    send_item(rcpfa_pkg::OP_RELEASE, rcpfa_pkg::PGNUM_W'(300));
    send_item(rcpfa_pkg::OP_SHARE, rcpfa_pkg::PGNUM_W'(300));
    send_item(rcpfa_pkg::OP_SHARE, rcpfa_pkg::PGNUM_W'(256));
    send_item(rcpfa_pkg::OP_RELEASE, rcpfa_pkg::PGNUM_W'(256));
    send_item(rcpfa_pkg::OP_RELEASE, rcpfa_pkg::PGNUM_W'(256));
    send_item(rcpfa_pkg::OP_RELEASE, rcpfa_pkg::PGNUM_W'(256));

    // Two-page window: fill it, run out of memory, free a page and reuse it.
    drain();
    set_window(4094, 4096);
    send_item(rcpfa_pkg::OP_ALLOC, '0);
    send_item(rcpfa_pkg::OP_ALLOC, '1);
    send_item(rcpfa_pkg::OP_ALLOC, '0);
    send_item(rcpfa_pkg::OP_RELEASE, rcpfa_pkg::PGNUM_W'(4095));
    send_item(rcpfa_pkg::OP_ALLOC, '0);

    // Whole store: page zero is granted, the held last page is shared, page zero is released.
    drain();
    set_window(0, 4096);
    send_item(rcpfa_pkg::OP_ALLOC, '0);
    send_item(rcpfa_pkg::OP_SHARE, rcpfa_pkg::PGNUM_W'(4095));
    send_item(rcpfa_pkg::OP_RELEASE, '0);

    // Random phases, each under its own window.
    for (int ph = 0; ph < NPHASES; ph++) begin
      drain();
      set_window(ph_first[ph], ph_limit[ph]);
      if (ph_burst[ph]) share_burst();
      repeat (ph_items[ph]) send_item(pick_op(), pick_page());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
